### rtl/bfr_pkg.sv
`timescale 1ns / 1ps

package bfr_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = 11;
  localparam int ROW_W     = 13;
  localparam int OUT_W     = 23;
  localparam int AREA_W    = WID_W + ROW_W;
  localparam int CH_W      = 8;
  localparam int NCH       = 3;
  localparam int PX_W      = NCH * CH_W;
  localparam int SUM_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 13;

  localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
  localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  // floor(s / 9) == (s * 3641) >> 15 for every s up to 9 * 255
  localparam int RECIP9   = 3641;
  localparam int RECIP9_SH = 15;
  localparam int PROD_W   = 2 * SUM_W;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [PX_W-1:0]  px_t;
  typedef logic [NCH-1:0][SUM_W-1:0] sums_t;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic            flush;
  } px_beat_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;
  } mean_beat_t;

  // per-item control decided at accept time from the position counters
  typedef struct packed {
    logic up_ok;
    logic mid_ok;
    logic pix_ok;
    logic col_nz;
    logic emit;
    logic last;
  } ctl_t;

  function automatic logic [CH_W-1:0] chan(input px_t px, input int ch);
    return px[PX_W-1-CH_W*ch -: CH_W];
  endfunction

  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(RECIP9);
    return p[RECIP9_SH +: CH_W];
  endfunction

endpackage

### rtl/box_filter_3x3_rgb.sv
`timescale 1ns / 1ps

// channel | handshake              | payload
// --------+------------------------+--------------------------------------
// pixel   | px_valid / px_ready    | px_data   (r, g, b, flush)
// mean    | mean_valid / mean_ready| mean_data (r, g, b means, frame_end)
// config  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one pixel beat per clock while px_ready is high; a result reaches the output
// register by way of the line store read at the accept edge, the registered
// window sum, then the divide by nine into the output register
// rst clears counters, window and valids; line stores are not cleared,
// rows above and below the frame are masked instead
// a waiting result stalls the pipe only when an emitting item reaches the
// last stage; beats that give no result keep flowing behind it

module box_filter_3x3_rgb import bfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 px_valid,
  output logic                 px_ready,
  input  px_beat_t             px_data,
  output logic                 mean_valid,
  input  logic                 mean_ready,
  output mean_beat_t           mean_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [WID_W-1:0] frame_width;
  logic [ROW_W-1:0] frame_height;

  logic  en;
  logic  accept;
  ctl_t  ctl;
  col_t  col;

  // stage 1: line store data arrives, window sums formed
  logic  s1_valid;
  ctl_t  s1_ctl;
  px_t   s1_pix;
  col_t  s1_addr;

  // stage 2: sums registered, divide feeds the output register
  logic  s2_valid;
  logic  s2_emit;
  logic  s2_last;
  sums_t sums;

  px_t   upper_q;
  px_t   middle_q;
  px_t   wr_upper;
  px_t   wr_middle;

  // hold only when the output is full and stage 2 has a result for it
  assign en       = !(mean_valid && !mean_ready && s2_valid && s2_emit);
  assign px_ready = en;
  assign accept   = px_valid && px_ready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[WID_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // position counters and per-beat masks
  bfr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .flush        (px_data.flush),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .ctl          (ctl),
    .col          (col)
  );

  // the two row buffers, read on accept, written back from stage 1
  bfr_line_mem u_line_mem (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (col),
    .wr_en     (en && s1_valid),
    .wr_addr   (s1_addr),
    .wr_upper  (wr_upper),
    .wr_middle (wr_middle),
    .upper_q   (upper_q),
    .middle_q  (middle_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl  <= ctl;
      s1_pix  <= {px_data.red_in, px_data.green_in, px_data.blue_in};
      s1_addr <= col;
    end
    if (en) begin
      s2_emit <= s1_ctl.emit;
      s2_last <= s1_ctl.last;
    end
  end

  // 3x3 window columns and channel sums
  bfr_window u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .step      (en && s1_valid),
    .ctl       (s1_ctl),
    .pix       (s1_pix),
    .upper_q   (upper_q),
    .middle_q  (middle_q),
    .sums      (sums),
    .wr_upper  (wr_upper),
    .wr_middle (wr_middle)
  );

  // output register: divide by nine through a reciprocal multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
    end else if (en && s2_valid && s2_emit) begin
      mean_valid <= 1'b1;
    end else if (mean_ready) begin
      mean_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid && s2_emit) begin
      mean_data.red_out   <= div9(sums[0]);
      mean_data.green_out <= div9(sums[1]);
      mean_data.blue_out  <= div9(sums[2]);
      mean_data.frame_end <= s2_last;
    end
  end

  // after the last beat of a frame the position is back at the top-left
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && ctl.last |=> !ctl.emit)
    else $error("position not reset after frame end");

  // a stalled stage 1 keeps its item and address
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !en |=> s1_valid && $stable(s1_addr))
    else $error("stage 1 item lost during stall");

  // an emitting item leaving stage 2 always lands in the output register
  a_s2_lands: assert property (@(posedge clk) disable iff (rst)
    en && s2_valid && s2_emit |=> mean_valid)
    else $error("result dropped at output register");

endmodule

### rtl/bfr_line_mem.sv
`timescale 1ns / 1ps

module bfr_line_mem import bfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic rd_en,
  input  col_t rd_addr,
  input  logic wr_en,
  input  col_t wr_addr,
  input  px_t  wr_upper,
  input  px_t  wr_middle,
  output px_t  upper_q,
  output px_t  middle_q
);

  px_t  upper_mem  [MAX_WIDTH];
  px_t  middle_mem [MAX_WIDTH];
  px_t  upper_rd;
  px_t  middle_rd;
  px_t  upper_fw;
  px_t  middle_fw;
  logic fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      upper_rd  <= upper_mem[rd_addr];
      middle_rd <= middle_mem[rd_addr];
      upper_fw  <= wr_upper;
      middle_fw <= wr_middle;
    end
  end

  // same-entry write in the read cycle: take the new data instead
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign upper_q  = fwd ? upper_fw : upper_rd;
  assign middle_q = fwd ? middle_fw : middle_rd;

endmodule

### rtl/bfr_ctrl.sv
`timescale 1ns / 1ps

module bfr_ctrl import bfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             flush,
  input  logic [WID_W-1:0] frame_width,
  input  logic [ROW_W-1:0] frame_height,
  output ctl_t             ctl,
  output col_t             col
);

  logic [ROW_W-1:0]  row;
  logic [OUT_W-1:0]  out_cnt;
  col_t              col_next;
  logic [ROW_W-1:0]  row_next;
  logic [OUT_W-1:0]  out_cnt_next;
  logic [WID_W-1:0]  w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [AREA_W-1:0] area;
  logic [ROW_W-1:0]  col_inc;
  logic              wrap;

  always_comb begin
    w_eff = (frame_width == '0) ? WID_W'(1) :
            ((32'(frame_width) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : frame_width);
    h_eff = (frame_height == '0) ? ROW_W'(1) : frame_height;
    area  = AREA_W'(w_eff) * AREA_W'(h_eff);

    col_inc = ROW_W'(col) + ROW_W'(1);
    wrap    = col_inc >= ROW_W'(w_eff);

    ctl.emit   = (row >= ROW_W'(2)) || ((row == ROW_W'(1)) && (col != '0));
    ctl.up_ok  = (row >= ROW_W'(2)) &&
                 ({1'b0, row} <= ({1'b0, h_eff} + (ROW_W + 1)'(1)));
    ctl.mid_ok = (row != '0) && (row <= h_eff);
    ctl.pix_ok = !flush && (row < h_eff);
    ctl.col_nz = col != '0;
    ctl.last   = ctl.emit && (AREA_W'(out_cnt) >= (area - AREA_W'(1)));

    col_next     = wrap ? '0 : col_inc[COL_W-1:0];
    row_next     = (wrap && (row != '1)) ? row + ROW_W'(1) : row;
    out_cnt_next = ctl.emit ? out_cnt + OUT_W'(1) : out_cnt;
    if (ctl.last) begin
      col_next     = '0;
      row_next     = '0;
      out_cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      out_cnt <= '0;
    end else if (accept) begin
      col     <= col_next;
      row     <= row_next;
      out_cnt <= out_cnt_next;
    end
  end

endmodule

### rtl/bfr_window.sv
`timescale 1ns / 1ps

module bfr_window import bfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  step,
  input  ctl_t  ctl,
  input  px_t   pix,
  input  px_t   upper_q,
  input  px_t   middle_q,
  output sums_t sums,
  output px_t   wr_upper,
  output px_t   wr_middle
);

  px_t   col_a [NCH];
  px_t   col_b [NCH];
  px_t   cur   [NCH];
  sums_t sums_next;

  always_comb begin
    cur[0] = ctl.up_ok  ? upper_q  : '0;
    cur[1] = ctl.mid_ok ? middle_q : '0;
    cur[2] = ctl.pix_ok ? pix      : '0;
    for (int ch = 0; ch < NCH; ch++) begin
      sums_next[ch] = '0;
      for (int k = 0; k < NCH; k++) begin
        sums_next[ch] = sums_next[ch] + SUM_W'(chan(col_a[k], ch)) +
                        SUM_W'(chan(col_b[k], ch)) +
                        (ctl.col_nz ? SUM_W'(chan(cur[k], ch)) : SUM_W'(0));
      end
    end
  end

  // upper row takes the old middle row unmasked; middle takes the new pixel
  assign wr_upper  = middle_q;
  assign wr_middle = cur[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NCH; k++) begin
        col_a[k] <= '0;
        col_b[k] <= '0;
      end
    end else if (step) begin
      for (int k = 0; k < NCH; k++) begin
        col_a[k] <= (ctl.col_nz && !ctl.last) ? col_b[k] : '0;
        col_b[k] <= ctl.last ? '0 : cur[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sums <= sums_next;
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

// bench for the 3x3 rgb box filter: a pixel raster goes in, one truncated
// window mean per pixel comes out one row plus one pixel later
//
// every pixel beat that the block takes is also fed to a bench-side copy of
// the filter (line stores, window columns, position counters, geometry regs)
// and each mean it yields is queued; the result monitor pops the oldest one
// for every mean beat taken and compares it field by field
//
// geometry is only rewritten with the pipe drained; width only moves at a
// frame start or at a row start once two full rows are stored, so the
// block never reads a line store entry that this frame has not written

module testbench;
  import bfr_pkg::*;

  localparam int unsigned ROW_SAT       = (1 << ROW_W) - 1;
  localparam int unsigned OUT_MASK      = (1 << OUT_W) - 1;
  // wait after the last mean is in, with margin for the pipe to empty
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 px_valid   = 1'b0;
  logic                 px_ready;
  px_beat_t             px_data    = '0;
  logic                 mean_valid;
  logic                 mean_ready = 1'b0;
  mean_beat_t           mean_data;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data   = '0;

  // idle rates in percent, switched per phase
  int unsigned send_gap_pct   = 9;
  int unsigned recv_stall_pct = 52;

  // long receiver hold-off: a test bumps hold_seq, the receiver loads hold_len
  int unsigned hold_len  = 0;
  int unsigned hold_seq  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  mean_beat_t  means_due [$];
  int unsigned mismatches  = 0;
  int unsigned pixels_sent = 0;

  // bench copy of the filter state
  logic [WID_W-1:0] width_reg;
  logic [ROW_W-1:0] height_reg;
  px_t              upper_row  [MAX_WIDTH];
  px_t              middle_row [MAX_WIDTH];
  px_t              win_cols   [6];
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      out_pos;

  box_filter_3x3_rgb u_dut (
    .clk        (clk),
    .rst        (rst),
    .px_valid   (px_valid),
    .px_ready   (px_ready),
    .px_data    (px_data),
    .mean_valid (mean_valid),
    .mean_ready (mean_ready),
    .mean_data  (mean_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // advance the filter copy by one pixel beat; returns 1 when a mean is due
  function automatic bit predict_means(input px_beat_t beat, output mean_beat_t mean);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned ci;
    int unsigned sum [3];
    px_t         cur [3];
    bit          emit;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (height_reg == 0) ? 1 : height_reg;
    r = row_pos;
    c = col_pos;
    ci = (c < MAX_WIDTH) ? c : 0;
    mean = '0;
    // first mean is for pixel (0,0), due when (1,1) arrives
    emit = (r >= 2) || (r == 1 && c >= 1);

    // rows above the frame and below it read as zero; flush beats are zero pixels
    cur[0] = (r >= 2 && r <= h + 1) ? upper_row[ci] : '0;
    cur[1] = (r >= 1 && r <= h) ? middle_row[ci] : '0;
    cur[2] = (beat.flush || r >= h) ? '0 : {beat.red_in, beat.green_in, beat.blue_in};

    for (int j = 0; j < NCH; j++) sum[j] = 0;
    for (int k = 0; k < 6; k++)
      for (int j = 0; j < NCH; j++)
        sum[j] += win_cols[k][PX_W-1-CH_W*j -: CH_W];
    // incoming column belongs to the window unless it wrapped to a new row
    if (c != 0)
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < NCH; j++)
          sum[j] += cur[k][PX_W-1-CH_W*j -: CH_W];

    for (int k = 0; k < 3; k++) begin
      win_cols[k]     = (c == 0) ? '0 : win_cols[k+3];
      win_cols[k + 3] = cur[k];
    end
    upper_row[ci]  = middle_row[ci];
    middle_row[ci] = cur[2];

    if (c + 1 >= w) begin
      col_pos = 0;
      if (row_pos < ROW_SAT) row_pos++;
    end else begin
      col_pos = c + 1;
    end

    if (emit) begin
      mean.red_out   = CH_W'(sum[0] / 9);
      mean.green_out = CH_W'(sum[1] / 9);
      mean.blue_out  = CH_W'(sum[2] / 9);
      // a shrunk frame ends as soon as the count is at or past the new area
      if (out_pos >= w * h - 1) begin
        mean.frame_end = 1'b1;
        col_pos  = 0;
        row_pos  = 0;
        out_pos  = 0;
        win_cols = '{default: '0};
      end else begin
        mean.frame_end = 1'b0;
        out_pos = (out_pos + 1) & OUT_MASK;
      end
    end
    return emit;
  endfunction

  function automatic px_beat_t random_beat(input bit is_flush);
    px_beat_t beat;
    beat.red_in   = CH_W'($urandom);
    beat.green_in = CH_W'($urandom);
    beat.blue_in  = CH_W'($urandom);
    beat.flush    = is_flush;
    return beat;
  endfunction

  // offer one pixel beat, with random gaps in front; valid stays up on return
  task automatic send_pixel(input px_beat_t beat);
    mean_beat_t mean;
    while ($urandom_range(99) < send_gap_pct) begin
      px_valid <= 1'b0;
      @(posedge clk);
    end
    px_valid <= 1'b1;
    px_data  <= beat;
    @(posedge clk);
    while (!px_ready) @(posedge clk);
    if (predict_means(beat, mean)) means_due.push_back(mean);
    pixels_sent++;
  endtask

  // more = 1 keeps cfg_valid up for a back-to-back write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FRAME_WIDTH) width_reg = data[WID_W-1:0];
    else height_reg = data[ROW_W-1:0];
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w_data, input logic [CFG_W-1:0] h_data);
    write_reg(CFG_FRAME_WIDTH, w_data, 1'b1);
    write_reg(CFG_FRAME_HEIGHT, h_data, 1'b0);
  endtask

  // pause the pixel side until every mean is in and the pipe has emptied
  task automatic wait_idle();
    px_valid <= 1'b0;
    while (means_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // drain with flush beats until the position is back at a frame start
  task automatic finish_frame();
    while (row_pos != 0 || col_pos != 0) send_pixel(random_beat(1'b1));
  endtask

  // w, h are the effective sizes; noisy mixes in flushes inside the frame,
  // short drains and masked pixels in the drain
  task automatic send_frame(input int unsigned w, input int unsigned h, input bit noisy);
    int unsigned drain;
    for (int unsigned i = 0; i < w * h; i++)
      send_pixel(random_beat(noisy && $urandom_range(99) < 4));
    drain = w + 1;
    if (noisy && $urandom_range(99) < 12) drain = $urandom_range(w);
    for (int unsigned i = 0; i < drain; i++)
      send_pixel(random_beat(!(noisy && $urandom_range(99) < 15)));
  endtask

  task automatic test_directed_frames();
    px_beat_t seq [13];
    // width 3 written with the spare upper bits set, they must be dropped
    set_geometry(13'h1803, 13'd3);
    seq = '{
      '{8'd255, 8'd255, 8'd255, 1'b0},
      '{8'd255, 8'd255, 8'd255, 1'b0},
      '{8'd255, 8'd255, 8'd255, 1'b0},
      '{8'd255, 8'd0,   8'd255, 1'b0},
      '{8'd255, 8'd255, 8'd255, 1'b1},  // flush inside the frame: zero pixel
      '{8'd0,   8'd255, 8'd0,   1'b0},
      '{8'haa,  8'h55,  8'h01,  1'b0},
      '{8'd0,   8'd0,   8'd0,   1'b0},
      '{8'd255, 8'd255, 8'd255, 1'b0},
      '{8'd17,  8'd34,  8'd51,  1'b1},
      '{8'd255, 8'd255, 8'd255, 1'b0},  // pixel below the last row: masked
      '{8'd0,   8'd0,   8'd0,   1'b1},
      '{8'd255, 8'd255, 8'd255, 1'b1}
    };
    foreach (seq[i]) send_pixel(seq[i]);
    wait_idle();

    // single pixel frame, then zero sizes which act as one
    set_geometry(13'd1, 13'd1);
    send_pixel('{8'd255, 8'd128, 8'd1, 1'b0});
    send_pixel(random_beat(1'b1));
    send_pixel(random_beat(1'b1));
    wait_idle();
    set_geometry(13'd0, 13'd0);
    send_pixel('{8'd200, 8'd9, 8'd255, 1'b0});
    send_pixel(random_beat(1'b1));
    send_pixel(random_beat(1'b1));
    wait_idle();
  endtask

  // geometry rewritten while a frame is open
  task automatic test_live_resize();
    set_geometry(13'd4, 13'd6);
    repeat (12) send_pixel(random_beat(1'b0));
    wait_idle();
    // height cut to the rows already in: the rest of the frame is masked
    write_reg(CFG_FRAME_HEIGHT, 13'd3, 1'b0);
    finish_frame();
    wait_idle();

    set_geometry(13'd6, 13'd5);
    repeat (18) send_pixel(random_beat(1'b0));
    wait_idle();
    // narrower rows from a row start, area already passed: frame ends at next mean
    set_geometry(13'd3, 13'd2);
    finish_frame();
    wait_idle();
  endtask

  // receiver blocked long enough to back the pipe up into the pixel side
  task automatic test_backpressure();
    set_geometry(13'd5, 13'd8);
    hold_len = 300;
    hold_seq++;
    send_frame(5, 8, 1'b0);
    wait_idle();
    send_frame(5, 8, 1'b1);
    finish_frame();
    wait_idle();
  endtask

  // single column frame, then a single row frame with spare width bits set
  task automatic test_extreme_geometry();
    set_geometry(13'd1, 13'd16);
    send_frame(1, 16, 1'b0);
    wait_idle();
    set_geometry(13'h0810, 13'd1);
    send_frame(16, 1, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_frames(input int unsigned gap_pct, input int unsigned stall_pct,
                                    input int unsigned goal);
    int unsigned start;
    int unsigned w;
    int unsigned h;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    start = pixels_sent;
    while (pixels_sent - start < goal) begin
      finish_frame();
      wait_idle();
      w = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      h = $urandom_range(1, 8);
      // spare width bits random, the block must ignore them
      set_geometry(CFG_W'({2'($urandom), WID_W'(w)}), CFG_W'(h));
      repeat ($urandom_range(1, 3)) send_frame(w, h, 1'b1);
    end
    finish_frame();
    wait_idle();
  endtask

  // receiver: random stalls, or a counted hold-off when a test asks for one
  always @(posedge clk) begin
    if (rst) begin
      mean_ready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_seen != hold_seq) begin
      hold_seen  <= hold_seq;
      hold_left  <= hold_len;
      mean_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      mean_ready <= 1'b0;
    end else begin
      mean_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor: every mean beat taken must match the oldest prediction
  always @(posedge clk) begin
    mean_beat_t want;
    if (!rst && mean_valid && mean_ready) begin
      if (means_due.size() == 0) begin
        if (mismatches < 10)
          $display("mean beat with none pending: r%0d g%0d b%0d end%0b",
                   mean_data.red_out, mean_data.green_out, mean_data.blue_out,
                   mean_data.frame_end);
        mismatches++;
      end else begin
        want = means_due.pop_front();
        if (mean_data.red_out !== want.red_out || mean_data.green_out !== want.green_out ||
            mean_data.blue_out !== want.blue_out || mean_data.frame_end !== want.frame_end)
        begin
          if (mismatches < 10)
            $display("mean mismatch: expected r%0d g%0d b%0d end%0b, got r%0d g%0d b%0d end%0b",
                     want.red_out, want.green_out, want.blue_out, want.frame_end,
                     mean_data.red_out, mean_data.green_out, mean_data.blue_out,
                     mean_data.frame_end);
          mismatches++;
        end
      end
    end
  end

  initial begin
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    col_pos    = 0;
    row_pos    = 0;
    out_pos    = 0;
    win_cols   = '{default: '0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_live_resize();
    test_backpressure();
    test_extreme_geometry();
    test_random_frames(9, 52, 70);
    test_random_frames(52, 9, 70);
    test_random_frames(0, 0, 70);

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
